@@ hw/rtl/mlfq_pkg.sv @@
package mlfq_pkg;

  // Field and register widths
  localparam int OP_W      = 2;
  localparam int PID_IN_W  = 5;
  localparam int USAGE_W   = 8;
  localparam int STATUS_W  = 3;
  localparam int LVL_W     = 2;
  localparam int TIME_W    = 33;
  localparam int BASE_W    = 30;
  localparam int SPAWN_W   = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = BASE_W;

  localparam int NUM_QUEUES   = 4;
  localparam int NUM_PIDS_DEF = 32;

  // Reset values of the registers
  localparam logic [BASE_W-1:0]  BASE_RESET  = BASE_W'(10000000);
  localparam logic [SPAWN_W-1:0] SPAWN_RESET = SPAWN_W'(20);

  // Percent scaling: x/100 as (x * DIV_MAGIC) >> DIV_SHIFT, exact for x < 2^32
  localparam int PERCENT   = 100;
  localparam int DIV_W     = 24;
  localparam int DIV_SHIFT = 37;
  localparam int DIV_PW    = DIV_SHIFT + DIV_W;
  localparam logic [DIV_PW-1:0] DIV_MAGIC  = DIV_PW'(64'd1374389535);
  localparam logic [DIV_W-1:0]  DIV_RESET  = DIV_W'(10000000 / PERCENT);
  localparam logic [USAGE_W-1:0] USAGE_FULL = USAGE_W'(PERCENT);

  localparam int BP_W = USAGE_W + DIV_W;
  localparam logic [TIME_W-1:0] TIME_MAX = TIME_W'(64'd8589934584);

  // Queue levels
  localparam logic [LVL_W-1:0] LVL_RR   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_FIRST = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LAST = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_QUANTUM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPAWNS   = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_SPAWN    = 2'd0,
    OP_UNBLOCK  = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_REPORT   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED     = 3'd0,
    ST_DISPATCHED = 3'd1,
    ST_BLOCKED    = 3'd2,
    ST_TERMINATED = 3'd3,
    ST_REFUSED    = 3'd4,
    ST_IDLE       = 3'd5,
    ST_INVALID    = 3'd6
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } mlfq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
  } mlfq_sts_t;

endpackage

@@ hw/rtl/mlfq_if.sv @@
interface mlfq_in_if import mlfq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            opcode;
  logic                       realtime_req;
  logic [PID_IN_W-1:0]        pid;
  logic signed [USAGE_W-1:0]  usage;

  modport source (output valid, opcode, realtime_req, pid, usage, input ready);
  modport sink (input valid, opcode, realtime_req, pid, usage, output ready);
endinterface

interface mlfq_out_if import mlfq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [PID_IN_W-1:0]  pid_res;
  logic [LVL_W-1:0]     level;
  logic [TIME_W-1:0]    quantum_ns;
  logic [TIME_W-1:0]    burst_ns;

  modport source (output valid, status, pid_res, level, quantum_ns, burst_ns, input ready);
  modport sink (input valid, status, pid_res, level, quantum_ns, burst_ns, output ready);
endinterface

@@ hw/rtl/mlfq_ctrl.sv @@
module mlfq_ctrl import mlfq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mlfq_sts_t sts,
  output mlfq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // Take a beat in idle, commit it once the output slot is free
  assign cmd.capture = in_valid & in_ready;
  assign cmd.commit  = (state == S_EXEC) & sts.slot_free;

  // Hold state and the ready flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_EXEC;
            in_ready <= 1'b0;
          end
        end
        S_EXEC: begin
          if (sts.slot_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/mlfq_dp.sv @@
module mlfq_dp import mlfq_pkg::*; #(
  parameter int NUM_PIDS = NUM_PIDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mlfq_cmd_t                 cmd,
  output mlfq_sts_t                 sts,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic [OP_W-1:0]           opcode,
  input  logic                      realtime_req,
  input  logic [PID_IN_W-1:0]       pid,
  input  logic signed [USAGE_W-1:0] usage,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       status,
  output logic [PID_IN_W-1:0]       pid_res,
  output logic [LVL_W-1:0]          level,
  output logic [TIME_W-1:0]         quantum_ns,
  output logic [TIME_W-1:0]         burst_ns
);

  localparam int PW   = $clog2(NUM_PIDS);
  localparam int CW   = PW + 1;
  localparam int QW   = $clog2(NUM_QUEUES);
  localparam int FD   = NUM_QUEUES << PW;
  localparam int LD   = 1 << PW;
  localparam int SH_W = BP_W + 3;
  localparam logic [PW-1:0] PID_LAST = PW'(NUM_PIDS - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(NUM_PIDS);

  // Configuration
  logic [BASE_W-1:0]  base_quantum;
  logic [SPAWN_W-1:0] max_spawns;
  logic [DIV_W-1:0]   base_div;
  logic [DIV_PW-1:0]  div_full;

  // Scheduler state
  logic [NUM_PIDS-1:0] free_map;
  logic [NUM_PIDS-1:0] blocked_map;
  logic [SPAWN_W-1:0]  spawn_count;
  logic                run_valid;
  logic [PW-1:0]       run_pid;
  logic [LVL_W-1:0]    run_level;
  logic [PW-1:0]       q_head  [NUM_QUEUES];
  logic [PW-1:0]       q_tail  [NUM_QUEUES];
  logic [CW-1:0]       q_count [NUM_QUEUES];
  logic [PW-1:0]       fifo_mem [FD];
  logic [LVL_W-1:0]    lvl_mem  [LD];

  // Captured beat and read data
  op_t                 op_q;
  logic                rt_q;
  logic [PID_IN_W-1:0] pin_q;
  logic [USAGE_W-1:0]  u_q;
  logic [PW-1:0]       fifo_rd;
  logic [LVL_W-1:0]    lvl_rd;
  logic [BP_W-1:0]     burst_prod;

  // Combinational helpers
  logic [QW-1:0]          qsel;
  logic                   q_any;
  logic                   found;
  logic [PW-1:0]          free_idx;
  logic [PW+PID_IN_W-1:0] in_ext;
  logic [PW+PID_IN_W-1:0] pq_ext;
  logic [PW-1:0]          in_idx;
  logic [PW-1:0]          pq_idx;
  logic                   pq_ok;
  logic [USAGE_W-1:0]     mag;
  logic [SH_W-1:0]        burst_shift;
  logic [TIME_W-1:0]      burst_sat;

  // Commit decisions
  status_t          res_status;
  logic [PW-1:0]    res_pid;
  logic [LVL_W-1:0] res_level;
  logic [TIME_W-1:0] res_quantum;
  logic [TIME_W-1:0] res_burst;
  logic [PW-1:0]    act_pid;
  logic             push_en;
  logic [QW-1:0]    push_q;
  logic             pop_en;
  logic             lvl_we;
  logic             free_clr;
  logic             free_set;
  logic             blk_clr;
  logic             blk_set;
  logic             spawn_inc;
  logic             run_start;
  logic             run_stop;
  logic [PW+PID_IN_W-1:0] res_ext;

  // Fit pids between the 5-bit fields and the internal width
  assign in_ext  = {{PW{1'b0}}, pid};
  assign pq_ext  = {{PW{1'b0}}, pin_q};
  assign in_idx  = in_ext[PW-1:0];
  assign pq_idx  = pq_ext[PW-1:0];
  assign pq_ok   = 32'(pin_q) < 32'(NUM_PIDS);
  assign mag     = usage[USAGE_W-1] ? USAGE_W'(-usage) : USAGE_W'(usage);
  assign div_full = DIV_PW'(cfg_data) * DIV_MAGIC;

  // Pick the first non-empty queue
  always_comb begin
    qsel  = '0;
    q_any = 1'b0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (q_count[i] != '0) begin
        qsel  = QW'(i);
        q_any = 1'b1;
      end
    end
  end

  // Find the lowest free pid
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = NUM_PIDS - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        found    = 1'b1;
        free_idx = PW'(i);
      end
    end
  end

  // Scale the burst by the run level and clamp it
  assign burst_shift = SH_W'(burst_prod) << run_level;
  assign burst_sat   = (burst_shift > SH_W'(TIME_MAX)) ? TIME_MAX : burst_shift[TIME_W-1:0];

  // Decide the outcome of the captured beat
  always_comb begin
    res_status  = ST_INVALID;
    res_pid     = '0;
    res_level   = LVL_RR;
    res_quantum = '0;
    res_burst   = '0;
    act_pid     = run_pid;
    push_en     = 1'b0;
    push_q      = '0;
    pop_en      = 1'b0;
    lvl_we      = 1'b0;
    free_clr    = 1'b0;
    free_set    = 1'b0;
    blk_clr     = 1'b0;
    blk_set     = 1'b0;
    spawn_inc   = 1'b0;
    run_start   = 1'b0;
    run_stop    = 1'b0;
    unique case (op_q)
      OP_SPAWN: begin
        if (!found || spawn_count >= max_spawns) begin
          res_status = ST_REFUSED;
        end else begin
          act_pid    = free_idx;
          res_pid    = free_idx;
          res_level  = rt_q ? LVL_RR : LVL_FIRST;
          res_status = ST_QUEUED;
          free_clr   = 1'b1;
          blk_clr    = 1'b1;
          lvl_we     = 1'b1;
          push_en    = 1'b1;
          push_q     = QW'(res_level);
          spawn_inc  = 1'b1;
        end
      end
      OP_UNBLOCK: begin
        res_pid = pq_idx;
        act_pid = pq_idx;
        if (pq_ok && blocked_map[pq_idx]) begin
          res_level  = (lvl_rd == LVL_RR) ? LVL_RR : LVL_FIRST;
          res_status = ST_QUEUED;
          blk_clr    = 1'b1;
          lvl_we     = 1'b1;
          push_en    = 1'b1;
          push_q     = QW'(res_level);
        end
      end
      OP_DISPATCH: begin
        if (run_valid) begin
          res_pid = run_pid;
        end else if (q_any) begin
          res_pid     = fifo_rd;
          res_level   = LVL_W'(qsel);
          res_quantum = TIME_W'(base_quantum) << qsel;
          res_status  = ST_DISPATCHED;
          pop_en      = 1'b1;
          run_start   = 1'b1;
        end else begin
          res_status = ST_IDLE;
        end
      end
      OP_REPORT: begin
        if (run_valid) begin
          res_pid   = run_pid;
          res_burst = burst_sat;
          run_stop  = 1'b1;
          if (u_q == USAGE_FULL) begin
            res_level  = (run_level == LVL_RR || run_level == LVL_LAST) ?
                         run_level : run_level + 2'd1;
            res_status = ST_QUEUED;
            lvl_we     = 1'b1;
            push_en    = 1'b1;
            push_q     = QW'(res_level);
          end else if (u_q[USAGE_W-1]) begin
            res_level  = (run_level == LVL_RR) ? LVL_RR : LVL_FIRST;
            res_status = ST_BLOCKED;
            lvl_we     = 1'b1;
            blk_set    = 1'b1;
          end else begin
            res_level  = run_level;
            res_status = ST_TERMINATED;
            free_set   = 1'b1;
            blk_clr    = 1'b1;
          end
        end
      end
      default: res_status = ST_INVALID;
    endcase
  end

  // Capture the beat, issue the memory reads and the burst multiply
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q       <= op_t'(opcode);
      rt_q       <= realtime_req;
      pin_q      <= pid;
      u_q        <= usage;
      fifo_rd    <= fifo_mem[{qsel, q_head[qsel]}];
      lvl_rd     <= lvl_mem[in_idx];
      burst_prod <= BP_W'(mag) * BP_W'(base_div);
    end
  end

  // Write the queue and level memories
  always_ff @(posedge clk) begin
    if (cmd.commit && push_en && q_count[push_q] < CNT_FULL) begin
      fifo_mem[{push_q, q_tail[push_q]}] <= act_pid;
    end
    if (cmd.commit && lvl_we) begin
      lvl_mem[act_pid] <= res_level;
    end
  end

  // Update configuration and scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_quantum <= BASE_RESET;
      max_spawns   <= SPAWN_RESET;
      base_div     <= DIV_RESET;
      free_map     <= '1;
      blocked_map  <= '0;
      spawn_count  <= '0;
      run_valid    <= 1'b0;
      run_pid      <= '0;
      run_level    <= LVL_RR;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        q_head[i]  <= '0;
        q_tail[i]  <= '0;
        q_count[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE_QUANTUM: begin
            base_quantum <= cfg_data;
            base_div     <= div_full[DIV_SHIFT +: DIV_W];
          end
          REG_MAX_SPAWNS: max_spawns <= cfg_data[SPAWN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        if (free_clr) free_map[act_pid] <= 1'b0;
        if (free_set) free_map[act_pid] <= 1'b1;
        if (blk_clr) blocked_map[act_pid] <= 1'b0;
        if (blk_set) blocked_map[act_pid] <= 1'b1;
        if (spawn_inc) spawn_count <= spawn_count + 1'b1;
        if (run_start) begin
          run_valid <= 1'b1;
          run_pid   <= fifo_rd;
          run_level <= LVL_W'(qsel);
        end
        if (run_stop) run_valid <= 1'b0;
        if (push_en && q_count[push_q] < CNT_FULL) begin
          q_tail[push_q]  <= (q_tail[push_q] == PID_LAST) ? '0 : q_tail[push_q] + 1'b1;
          q_count[push_q] <= q_count[push_q] + 1'b1;
        end
        if (pop_en) begin
          q_head[qsel]  <= (q_head[qsel] == PID_LAST) ? '0 : q_head[qsel] + 1'b1;
          q_count[qsel] <= q_count[qsel] - 1'b1;
        end
      end
    end
  end

  // Hold the result until the sink takes it
  assign res_ext = {{PID_IN_W{1'b0}}, res_pid};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Unblock echoes the pid field as given, even when it is out of range
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status     <= res_status;
      pid_res    <= (op_q == OP_UNBLOCK) ? pin_q : res_ext[PID_IN_W-1:0];
      level      <= res_level;
      quantum_ns <= res_quantum;
      burst_ns   <= res_burst;
    end
  end

  assign sts.slot_free = !out_valid || out_ready;

endmodule

@@ hw/rtl/mlfq_process_scheduler_unit.sv @@
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    opcode, realtime_req, pid, usage
// out_ch   out  valid/ready    status, pid_res, level, quantum_ns, burst_ns
// cfg      in   cfg_we only    cfg_index, cfg_data
//
// Each event is taken in S_IDLE, where the beat is captured and the queue
// memory, the level memory and the burst multiplier are read; S_EXEC commits it.
// A finished result sits in the output register; the next beat is taken
// while it waits, and its commit stalls until the result is taken.
// Synchronous reset clears the maps, queue pointers and counters at once.
module mlfq_process_scheduler_unit import mlfq_pkg::*; #(
  parameter int NUM_PIDS = NUM_PIDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  mlfq_in_if.sink              in_ch,
  mlfq_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  mlfq_cmd_t cmd;
  mlfq_sts_t sts;

  mlfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlfq_dp #(
    .NUM_PIDS (NUM_PIDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (in_ch.opcode),
    .realtime_req (in_ch.realtime_req),
    .pid          (in_ch.pid),
    .usage        (in_ch.usage),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .status       (out_ch.status),
    .pid_res      (out_ch.pid_res),
    .level        (out_ch.level),
    .quantum_ns   (out_ch.quantum_ns),
    .burst_ns     (out_ch.burst_ns)
  );

endmodule

@@ sim/mlfq_process_scheduler_unit_tb.sv @@
module mlfq_process_scheduler_unit_tb;
  import mlfq_pkg::*;

  localparam int NPIDS        = 32;
  localparam int IDLE_PCT     = 30;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 6;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_SHOWN    = 10;

  typedef struct {
    op_t               op;
    logic              realtime_req;
    logic [4:0]        pid;
    logic signed [7:0] usage;
  } sched_event_t;

  typedef struct {
    status_t     status;
    logic [4:0]  pid;
    logic [1:0]  level;
    logic [32:0] quantum;
    logic [32:0] burst;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mlfq_in_if  in_ch ();
  mlfq_out_if out_ch ();

  mlfq_process_scheduler_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Scheduler shadow state
  logic              pid_free [NPIDS];
  logic              pid_blocked [NPIDS];
  logic [1:0]        pid_level [NPIDS];
  logic [4:0]        level_fifo [NUM_QUEUES][$];
  logic [9:0]        spawns_done;
  logic              running_valid;
  logic [4:0]        running_pid;
  logic [BASE_W-1:0]  base_ns;
  logic [SPAWN_W-1:0] spawn_limit;

  sched_result_t expected_results [$];
  sched_result_t want;

  int  mismatches = 0;
  int  events_sent = 0;
  int  results_checked = 0;
  int  status_seen [8];
  int  cycles = 0;
  bit  in_gaps_on = 1'b1;
  logic out_gaps_on = 1'b1;
  logic hold_off = 1'b0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result sink: random stalls, or a hold-off while pressure is applied
  always @(posedge clk) begin
    if (rst || hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !out_gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic count_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("[%0d] %s: got st=%0d pid=%0d lvl=%0d q=%0d b=%0d", cycles, what,
               out_ch.status, out_ch.pid_res, out_ch.level, out_ch.quantum_ns,
               out_ch.burst_ns);
      if (what != "unexpected result")
        $display("        want st=%0d pid=%0d lvl=%0d q=%0d b=%0d", want.status,
                 want.pid, want.level, want.quantum, want.burst);
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready) begin
      results_checked++;
      if (!$isunknown(out_ch.status)) status_seen[out_ch.status]++;
      if (expected_results.size() == 0) begin
        count_mismatch("unexpected result");
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status || out_ch.pid_res !== want.pid ||
            out_ch.level !== want.level || out_ch.quantum_ns !== want.quantum ||
            out_ch.burst_ns !== want.burst)
          count_mismatch("result mismatch");
      end
    end
  end

  // Predict the result of one event and advance the shadow state
  function automatic sched_result_t schedule_event(sched_event_t ev);
    sched_result_t res;
    logic found;
    logic [1:0] lvl;
    logic [7:0] mag;
    logic [63:0] used;
    res = '{ST_INVALID, 5'd0, 2'd0, 33'd0, 33'd0};
    found = 1'b0;
    case (ev.op)
      OP_SPAWN: begin
        for (int i = 0; i < NPIDS; i++)
          if (!found && pid_free[i]) begin
            res.pid = 5'(i);
            found = 1'b1;
          end
        if (!found || spawns_done >= spawn_limit) begin
          res.status = ST_REFUSED;
          res.pid = 5'd0;
        end else begin
          lvl = ev.realtime_req ? LVL_RR : LVL_FIRST;
          pid_free[res.pid] = 1'b0;
          pid_blocked[res.pid] = 1'b0;
          pid_level[res.pid] = lvl;
          if (level_fifo[lvl].size() < NPIDS) level_fifo[lvl].push_back(res.pid);
          spawns_done = spawns_done + 10'd1;
          res.status = ST_QUEUED;
          res.level = lvl;
        end
      end
      OP_UNBLOCK: begin
        res.pid = ev.pid;
        if (pid_blocked[ev.pid]) begin
          lvl = (pid_level[ev.pid] == LVL_RR) ? LVL_RR : LVL_FIRST;
          pid_blocked[ev.pid] = 1'b0;
          pid_level[ev.pid] = lvl;
          if (level_fifo[lvl].size() < NPIDS) level_fifo[lvl].push_back(ev.pid);
          res.status = ST_QUEUED;
          res.level = lvl;
        end
      end
      OP_DISPATCH: begin
        if (running_valid) begin
          res.pid = running_pid;
        end else begin
          res.status = ST_IDLE;
          for (int q = 0; q < NUM_QUEUES; q++)
            if (!found && level_fifo[q].size() > 0) begin
              found = 1'b1;
              res.pid = level_fifo[q].pop_front();
              res.level = pid_level[res.pid];
              res.quantum = 33'(base_ns) << res.level;
              res.status = ST_DISPATCHED;
              running_valid = 1'b1;
              running_pid = res.pid;
            end
        end
      end
      default: begin
        if (running_valid) begin
          mag = ev.usage[7] ? (~ev.usage + 8'd1) : ev.usage;
          lvl = pid_level[running_pid];
          res.pid = running_pid;
          running_valid = 1'b0;
          used = (64'(mag) * 64'(base_ns / PERCENT)) << lvl;
          if (used > 64'(TIME_MAX)) used = 64'(TIME_MAX);
          res.burst = used[32:0];
          if (ev.usage == USAGE_FULL) begin
            // demote: round robin and the last level stay put
            if (lvl != LVL_RR && lvl != LVL_LAST) lvl = lvl + 2'd1;
            pid_level[res.pid] = lvl;
            if (level_fifo[lvl].size() < NPIDS) level_fifo[lvl].push_back(res.pid);
            res.status = ST_QUEUED;
          end else if (ev.usage[7]) begin
            // block: feedback levels restart at the first level
            if (lvl != LVL_RR) lvl = LVL_FIRST;
            pid_level[res.pid] = lvl;
            pid_blocked[res.pid] = 1'b1;
            res.status = ST_BLOCKED;
          end else begin
            pid_free[res.pid] = 1'b1;
            pid_blocked[res.pid] = 1'b0;
            res.status = ST_TERMINATED;
          end
          res.level = lvl;
        end
      end
    endcase
    return res;
  endfunction

  function automatic sched_event_t make_event(op_t op, int rt, int pid, int usage);
    sched_event_t ev;
    ev.op = op;
    ev.realtime_req = rt[0];
    ev.pid = 5'(pid);
    ev.usage = 8'(usage);
    return ev;
  endfunction

  // Pick an event that mostly follows a legal schedule, with some noise
  function automatic sched_event_t pick_event();
    sched_event_t ev;
    int r;
    int stuck [$];
    ev = make_event(op_t'($urandom_range(3)), $urandom_range(1), $urandom_range(31),
                    $urandom_range(255));
    r = $urandom_range(99);
    if (r < 8) return ev;
    for (int i = 0; i < NPIDS; i++) if (pid_blocked[i]) stuck.push_back(i);
    if (running_valid)
      ev.op = (r < 80) ? OP_REPORT : op_t'($urandom_range(2));
    else if (r < 50)
      ev.op = OP_DISPATCH;
    else if (r < 75)
      ev.op = OP_SPAWN;
    else
      ev.op = OP_UNBLOCK;
    if (ev.op == OP_UNBLOCK && stuck.size() > 0 && $urandom_range(99) < 80)
      ev.pid = 5'(stuck[$urandom_range(stuck.size() - 1)]);
    if (ev.op == OP_REPORT) begin
      r = $urandom_range(99);
      if (r < 35) ev.usage = 8'(PERCENT);
      else if (r < 65) ev.usage = 8'(-$urandom_range(1, 128));
      else ev.usage = 8'($urandom_range(127));
    end
    return ev;
  endfunction

  // Offer one event beat and predict its result once it is taken
  task automatic send_event(sched_event_t ev);
    if (in_gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= ev.op;
    in_ch.realtime_req <= ev.realtime_req;
    in_ch.pid <= ev.pid;
    in_ch.usage <= ev.usage;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_results.push_back(schedule_event(ev));
    events_sent++;
  endtask

  task automatic send_random(int count);
    repeat (count) send_event(pick_event());
  endtask

  // Stop offering and wait until every predicted result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic set_config(logic [BASE_W-1:0] base, logic [SPAWN_W-1:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= REG_BASE_QUANTUM;
    cfg_data <= CFG_W'(base);
    @(posedge clk);
    base_ns = base;
    cfg_index <= REG_MAX_SPAWNS;
    cfg_data <= CFG_W'(limit);
    @(posedge clk);
    spawn_limit = limit;
    cfg_we <= 1'b0;
  endtask

  // Walk two processes through every queue level and every report kind
  task automatic test_directed_events();
    send_event(make_event(OP_DISPATCH, 0, 0, 0));
    send_event(make_event(OP_REPORT, 1, 0, 50));
    send_event(make_event(OP_UNBLOCK, 1, 31, 0));
    send_event(make_event(OP_SPAWN, 1, 0, 0));
    send_event(make_event(OP_SPAWN, 0, 0, 0));
    send_event(make_event(OP_DISPATCH, 0, 0, 0));
    send_event(make_event(OP_DISPATCH, 1, 17, 127));
    send_event(make_event(OP_REPORT, 0, 0, 100));
    send_event(make_event(OP_DISPATCH, 0, 0, 0));
    send_event(make_event(OP_REPORT, 0, 0, -128));
    send_event(make_event(OP_UNBLOCK, 0, 0, 0));
    send_event(make_event(OP_DISPATCH, 0, 0, 0));
    send_event(make_event(OP_REPORT, 0, 0, 0));
    send_event(make_event(OP_DISPATCH, 0, 0, 0));
    send_event(make_event(OP_REPORT, 0, 0, 100));
    send_event(make_event(OP_DISPATCH, 0, 0, 0));
    send_event(make_event(OP_REPORT, 0, 0, 100));
    send_event(make_event(OP_DISPATCH, 0, 0, 0));
    send_event(make_event(OP_REPORT, 0, 0, 100));
    send_event(make_event(OP_DISPATCH, 0, 0, 0));
    send_event(make_event(OP_REPORT, 1, 31, -1));
    send_event(make_event(OP_UNBLOCK, 1, 1, -1));
    send_event(make_event(OP_DISPATCH, 0, 0, 0));
    send_event(make_event(OP_REPORT, 0, 0, 127));
    drain();
  endtask

  // Smallest and largest base slice; the largest saturates the burst
  task automatic test_extreme_quanta();
    set_config(BASE_W'(100), SPAWN_W'(1023));
    send_random(80);
    drain();
    set_config({BASE_W{1'b1}}, SPAWN_W'(1023));
    send_random(90);
    drain();
  endtask

  // Lifetime spawn limit, then every pid taken
  task automatic test_spawn_limits();
    set_config(BASE_W'($urandom_range(100, 2**BASE_W - 1)), SPAWN_W'(0));
    repeat (4) send_event(make_event(OP_SPAWN, $urandom_range(1), 0, 0));
    send_random(10);
    drain();
    set_config(base_ns, spawns_done + 10'd3);
    repeat (6) send_event(make_event(OP_SPAWN, $urandom_range(1), 0, 0));
    send_random(10);
    drain();
    set_config(base_ns, SPAWN_W'(1023));
    repeat (36)
      send_event(make_event(OP_SPAWN, $urandom_range(1), $urandom_range(31), 0));
    send_random(60);
    drain();
  endtask

  // Hold the result side off while events keep coming
  task automatic test_backpressure();
    in_gaps_on = 1'b0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    send_random(40);
    in_gaps_on = 1'b1;
    drain();
  endtask

  function automatic logic [BASE_W-1:0] BASE_DEF_VALUE();
    return BASE_RESET;
  endfunction

  // Random schedules over several settings, one stretch without any idling
  task automatic test_random_mix();
    set_config(BASE_DEF_VALUE(), SPAWN_W'($urandom_range(spawns_done, 1023)));
    send_random(100);
    drain();
    set_config(BASE_W'($urandom_range(100, 2**BASE_W - 1)), SPAWN_W'(1023));
    in_gaps_on = 1'b0;
    out_gaps_on <= 1'b0;
    send_random(120);
    in_gaps_on = 1'b1;
    out_gaps_on <= 1'b1;
    drain();
    set_config(BASE_W'($urandom_range(100, 100000)),
               SPAWN_W'($urandom_range(spawns_done, 1023)));
    send_random(100);
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_SPAWN;
    in_ch.realtime_req = 1'b0;
    in_ch.pid = '0;
    in_ch.usage = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_BASE_QUANTUM;
    cfg_data = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    // shadow state after reset
    for (int i = 0; i < NPIDS; i++) begin
      pid_free[i] = 1'b1;
      pid_blocked[i] = 1'b0;
      pid_level[i] = LVL_RR;
    end
    spawns_done = '0;
    running_valid = 1'b0;
    running_pid = '0;
    base_ns = BASE_RESET;
    spawn_limit = SPAWN_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_directed_events();
    test_extreme_quanta();
    test_spawn_limits();
    test_backpressure();
    test_random_mix();

    $display("ran %0d events (%0d spawns granted) over nine register settings",
             events_sent, spawns_done);
    $display("results: %0d checked, queued %0d, dispatched %0d, blocked %0d, terminated %0d,",
             results_checked, status_seen[ST_QUEUED], status_seen[ST_DISPATCHED],
             status_seen[ST_BLOCKED], status_seen[ST_TERMINATED]);
    $display("  refused %0d, idle %0d, invalid %0d; %0d mismatches",
             status_seen[ST_REFUSED], status_seen[ST_IDLE], status_seen[ST_INVALID],
             mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
